@@ design/gms_pkg.sv @@
// gms_pkg: shared types, codes and constants of the gait mode supervisor
// no dependencies
`default_nettype none

package gms_pkg;

    // gait modes
    localparam logic [2:0] MODE_STOP  = 3'd0;
    localparam logic [2:0] MODE_STAND = 3'd1;
    localparam logic [2:0] MODE_FWD   = 3'd2;
    localparam logic [2:0] MODE_BACK  = 3'd3;
    localparam logic [2:0] MODE_LEFT  = 3'd4;
    localparam logic [2:0] MODE_RIGHT = 3'd5;

    // item kinds
    localparam logic [1:0] OP_CMD   = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_PAUSE = 2'd2;

    // balance requests
    localparam logic [1:0] BAL_NONE    = 2'd0;
    localparam logic [1:0] BAL_DISABLE = 2'd1;
    localparam logic [1:0] BAL_ENABLE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SLEW      = 2'd0;
    localparam logic [1:0] REG_TILT_LIM  = 2'd1;
    localparam logic [1:0] REG_TILT_HOLD = 2'd2;
    localparam logic [1:0] REG_STEP_RATE = 2'd3;

    localparam logic [15:0] RST_SLEW      = 16'd131;
    localparam logic [14:0] RST_TILT_LIM  = 15'd11520;
    localparam logic [15:0] RST_TILT_HOLD = 16'd2000;
    localparam logic [31:0] RST_STEP_RATE = 32'd8589935;

    localparam logic [15:0] COAST_LIMIT = 16'd1311;
    localparam logic [31:0] MAX_DT_MS   = 32'd500;
    localparam int          DT_W        = 9;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 48;

    function automatic logic mode_walks(input logic [2:0] m);
        return (m == MODE_FWD) || (m == MODE_BACK) || (m == MODE_LEFT) || (m == MODE_RIGHT);
    endfunction

    // magnitude of a signed q8.8 angle, -32768 gives 32768
    function automatic logic [16:0] abs_angle(input logic [15:0] v);
        logic [16:0] ext;
        ext = {v[15], v};
        return v[15] ? (17'd0 - ext) : ext;
    endfunction

endpackage

`default_nettype wire

@@ design/gait_mode_supervisor_core.sv @@
// a command, pause, ignored or stale tick passes exec and emit; a tick that slews the speed
// adds the slew state, in a walking mode also sdist, ph_lo and ph_hi, set by passes through
// the shared 32x16 multiplier (slew limit, then speed*dt and two halves of the phase advance).
// one item at a time, taken again once the last result is loaded; a result-side stall delays that.
// synchronous active-low reset puts the block in stop mode, zero speed and phase, no
// fault, configuration at its default values
`default_nettype none

module gait_mode_supervisor_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_addr,
    input  wire logic [31:0]                   cfg_wdata,
    // input items
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // new_mode[2:0], cmd_speed[18:3], time_ms[50:19], pitch[66:51], roll[82:67],
    // servos_ready[83], balance_active[84], zero pad[87:85]
    input  wire logic [gms_pkg::S_DATA_W-1:0]  s_tdata,
    // operation[1:0]
    input  wire logic [1:0]                    s_tuser,
    // result items
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // mode[2:0], speed[18:3], phase[34:19], fault[35], bal_reset[36],
    // balance_request[38:37], motion_step[39], paused[40], zero pad[47:41]
    output logic      [gms_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int DT_W = gms_pkg::DT_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_SLEW, ST_SDIST, ST_PH_LO, ST_PH_HI, ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] slew_reg;
    logic [14:0] tilt_lim_reg;
    logic [15:0] hold_reg;
    logic [31:0] step_rate_reg;

    // supervisor state
    logic [2:0]  cur_mode_reg, cur_mode_next;
    logic [15:0] target_reg, target_next;
    logic [15:0] applied_reg, applied_next;
    logic        paused_reg, paused_next;
    logic [2:0]  def_mode_reg, def_mode_next;
    logic [15:0] def_speed_reg, def_speed_next;
    logic        has_def_reg, has_def_next;
    logic [31:0] phase_reg, phase_next;
    logic [31:0] last_tick_reg, last_tick_next;
    logic        fault_reg, fault_next;
    logic [31:0] fault_start_reg, fault_start_next;
    logic        bbf_reg, bbf_next;

    // per-item flags and working values
    logic           pulse_reg, pulse_next;
    logic [1:0]     req_reg, req_next;
    logic           motion_reg, motion_next;
    logic [DT_W-1:0] dt_reg, dt_next;
    logic [8:0]     sd_hi_reg, sd_hi_next;
    logic           m_tvalid_reg, m_tvalid_next;

    // latched item
    logic [1:0]  op_reg;
    logic [2:0]  nmode_reg;
    logic [15:0] nspeed_reg;
    logic [31:0] time_reg;
    logic [15:0] pitch_reg, roll_reg;
    logic        servo_reg, bal_reg;
    logic [gms_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic [gms_pkg::MUL_A_W-1:0] mul_a;
    logic [gms_pkg::MUL_B_W-1:0] mul_b;
    logic [gms_pkg::MUL_P_W-1:0] prod;

    logic s_accept, emit_load;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign emit_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    gms_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    always_comb begin
        logic [31:0] dt32;
        logic        tilt;
        logic        fault_v;
        logic [15:0] gap;
        logic [15:0] step;
        logic [15:0] app_v;
        logic [2:0]  mode_v;
        logic [24:0] lim;

        dt32 = time_reg - last_tick_reg;
        tilt = (gms_pkg::abs_angle(pitch_reg) > {2'b00, tilt_lim_reg})
            || (gms_pkg::abs_angle(roll_reg) > {2'b00, tilt_lim_reg});
        fault_v = fault_reg;
        gap  = '0;
        step = '0;
        app_v = applied_reg;
        mode_v = cur_mode_reg;
        lim = prod[24:0];

        state_next       = state_reg;
        cur_mode_next    = cur_mode_reg;
        target_next      = target_reg;
        applied_next     = applied_reg;
        paused_next      = paused_reg;
        def_mode_next    = def_mode_reg;
        def_speed_next   = def_speed_reg;
        has_def_next     = has_def_reg;
        phase_next       = phase_reg;
        last_tick_next   = last_tick_reg;
        fault_next       = fault_reg;
        fault_start_next = fault_start_reg;
        bbf_next         = bbf_reg;
        pulse_next       = pulse_reg;
        req_next         = req_reg;
        motion_next      = motion_reg;
        dt_next          = dt_reg;
        sd_hi_next       = sd_hi_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        mul_a            = '0;
        mul_b            = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                pulse_next  = 1'b0;
                req_next    = gms_pkg::BAL_NONE;
                motion_next = 1'b0;
                state_next  = ST_EMIT;
                if (op_reg == gms_pkg::OP_CMD) begin
                    if (nmode_reg <= gms_pkg::MODE_RIGHT) begin
                        paused_next = 1'b0;
                        if (nmode_reg == gms_pkg::MODE_STOP
                            || nmode_reg == gms_pkg::MODE_STAND) begin
                            has_def_next  = 1'b0;
                            target_next   = '0;
                            pulse_next    = (cur_mode_reg != nmode_reg);
                            cur_mode_next = nmode_reg;
                        end else if (gms_pkg::mode_walks(cur_mode_reg)
                            && ((cur_mode_reg == gms_pkg::MODE_BACK)
                                != (nmode_reg == gms_pkg::MODE_BACK))) begin
                            // reversal waits until the speed coasts down
                            def_mode_next  = nmode_reg;
                            def_speed_next = nspeed_reg;
                            has_def_next   = 1'b1;
                            target_next    = '0;
                        end else begin
                            has_def_next  = 1'b0;
                            target_next   = nspeed_reg;
                            pulse_next    = (cur_mode_reg != nmode_reg);
                            cur_mode_next = nmode_reg;
                        end
                    end
                end else if (op_reg == gms_pkg::OP_PAUSE) begin
                    paused_next = 1'b1;
                end else if (op_reg == gms_pkg::OP_TICK && servo_reg && !paused_reg) begin
                    last_tick_next = time_reg;
                    if (tilt && !fault_reg) begin
                        fault_v          = 1'b1;
                        fault_start_next = time_reg;
                        bbf_next         = bal_reg;
                        req_next         = gms_pkg::BAL_DISABLE;
                        pulse_next       = 1'b1;
                    end else if (!tilt && fault_reg
                        && ((time_reg - fault_start_reg) >= {16'd0, hold_reg})) begin
                        fault_v  = 1'b0;
                        req_next = bbf_reg ? gms_pkg::BAL_ENABLE : gms_pkg::BAL_NONE;
                        bbf_next = 1'b0;
                    end
                    fault_next = fault_v;
                    if ((tilt || fault_v) && gms_pkg::mode_walks(cur_mode_reg)) begin
                        has_def_next  = 1'b0;
                        target_next   = '0;
                        pulse_next    = 1'b1;
                        cur_mode_next = gms_pkg::MODE_STOP;
                    end
                    if (dt32 != 32'd0 && dt32 <= gms_pkg::MAX_DT_MS) begin
                        motion_next = 1'b1;
                        dt_next     = dt32[DT_W-1:0];
                        mul_a       = {16'd0, slew_reg};
                        mul_b       = {{(16-DT_W){1'b0}}, dt32[DT_W-1:0]};
                        state_next  = ST_SLEW;
                    end
                end
            end
            ST_SLEW: begin
                // step toward target, limited by slew * dt
                if (target_reg >= applied_reg) begin
                    gap   = target_reg - applied_reg;
                    step  = ({9'd0, gap} > lim) ? lim[15:0] : gap;
                    app_v = applied_reg + step;
                end else begin
                    gap   = applied_reg - target_reg;
                    step  = ({9'd0, gap} > lim) ? lim[15:0] : gap;
                    app_v = applied_reg - step;
                end
                applied_next = app_v;
                if (has_def_reg && app_v < gms_pkg::COAST_LIMIT) begin
                    pulse_next   = 1'b1;
                    mode_v       = def_mode_reg;
                    target_next  = def_speed_reg;
                    has_def_next = 1'b0;
                end
                cur_mode_next = mode_v;
                if (gms_pkg::mode_walks(mode_v)) begin
                    mul_a      = {16'd0, app_v};
                    mul_b      = {{(16-DT_W){1'b0}}, dt_reg};
                    state_next = ST_SDIST;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SDIST: begin
                // speed * dt is 25 bits: low half now, high bits next
                sd_hi_next = prod[24:16];
                mul_a      = step_rate_reg;
                mul_b      = prod[15:0];
                state_next = ST_PH_LO;
            end
            ST_PH_LO: begin
                phase_next = phase_reg + prod[47:16];
                mul_a      = step_rate_reg;
                mul_b      = {7'd0, sd_hi_reg};
                state_next = ST_PH_HI;
            end
            ST_PH_HI: begin
                phase_next = phase_reg + prod[31:0];
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_load) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cur_mode_reg    <= gms_pkg::MODE_STOP;
            target_reg      <= '0;
            applied_reg     <= '0;
            paused_reg      <= 1'b0;
            def_mode_reg    <= gms_pkg::MODE_STOP;
            def_speed_reg   <= '0;
            has_def_reg     <= 1'b0;
            phase_reg       <= '0;
            last_tick_reg   <= '0;
            fault_reg       <= 1'b0;
            fault_start_reg <= '0;
            bbf_reg         <= 1'b0;
            pulse_reg       <= 1'b0;
            req_reg         <= gms_pkg::BAL_NONE;
            motion_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cur_mode_reg    <= cur_mode_next;
            target_reg      <= target_next;
            applied_reg     <= applied_next;
            paused_reg      <= paused_next;
            def_mode_reg    <= def_mode_next;
            def_speed_reg   <= def_speed_next;
            has_def_reg     <= has_def_next;
            phase_reg       <= phase_next;
            last_tick_reg   <= last_tick_next;
            fault_reg       <= fault_next;
            fault_start_reg <= fault_start_next;
            bbf_reg         <= bbf_next;
            pulse_reg       <= pulse_next;
            req_reg         <= req_next;
            motion_reg      <= motion_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        dt_reg    <= dt_next;
        sd_hi_reg <= sd_hi_next;
        if (s_accept) begin
            op_reg     <= s_tuser;
            nmode_reg  <= s_tdata[2:0];
            nspeed_reg <= s_tdata[18:3];
            time_reg   <= s_tdata[50:19];
            pitch_reg  <= s_tdata[66:51];
            roll_reg   <= s_tdata[82:67];
            servo_reg  <= s_tdata[83];
            bal_reg    <= s_tdata[84];
        end
        if (emit_load) begin
            m_tdata_reg <= {7'd0, paused_reg, motion_reg, req_reg, pulse_reg, fault_reg,
                            phase_reg[31:16], applied_reg, cur_mode_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slew_reg      <= gms_pkg::RST_SLEW;
            tilt_lim_reg  <= gms_pkg::RST_TILT_LIM;
            hold_reg      <= gms_pkg::RST_TILT_HOLD;
            step_rate_reg <= gms_pkg::RST_STEP_RATE;
        end else if (cfg_we) begin
            case (cfg_addr)
                gms_pkg::REG_SLEW:      slew_reg      <= cfg_wdata[15:0];
                gms_pkg::REG_TILT_LIM:  tilt_lim_reg  <= cfg_wdata[14:0];
                gms_pkg::REG_TILT_HOLD: hold_reg      <= cfg_wdata[15:0];
                gms_pkg::REG_STEP_RATE: step_rate_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/gms_mul.sv @@
// gms_mul: shared 32 x 16 unsigned multiplier with registered product
// depends on gms_pkg for operand widths
`default_nettype none

module gms_mul (
    input  wire logic                         aclk,
    input  wire logic [gms_pkg::MUL_A_W-1:0]  op_a,
    input  wire logic [gms_pkg::MUL_B_W-1:0]  op_b,
    output logic      [gms_pkg::MUL_P_W-1:0]  prod
);

    logic [gms_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= gms_pkg::MUL_P_W'(op_a) * gms_pkg::MUL_P_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ design/gms_checker.sv @@
// gms_checker: port-level checks of the gait mode supervisor, bound to the top level
// depends on gms_pkg and gait_mode_supervisor_core
`default_nettype none

module gms_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [gms_pkg::M_DATA_W-1:0]  m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    a_req_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[38:37] != 2'd3)
        else $error("bad balance request code");

    a_mode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= gms_pkg::MODE_RIGHT)
        else $error("mode out of range");

    // motion only on ticks taken while not paused
    a_motion_paused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[39] && m_tdata[40]))
        else $error("motion step while paused");

endmodule

bind gait_mode_supervisor_core gms_checker u_gms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
